// ===== rtl/vas_pkg.sv =====
// ----------------------------------------------------------------------------
// vas_pkg
// Shared types and constants of the velocity arrow sampler.
// ----------------------------------------------------------------------------
package vas_pkg;

  localparam int MAX_GRID_DEF  = 1024;
  localparam int VEL_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int REG_W      = 11;
  localparam int WORD_W     = 16;

  localparam int STRIDE_W   = 17;
  localparam int STRIDE_MAX = 131071;

  localparam int POS_W      = 10;
  localparam int DIR_W      = 16;
  localparam int DIR_MAG_W  = 15;
  localparam int RATIO_W    = 16;
  localparam int RATIO_ONE  = 32768;
  localparam int COMP_LIMIT = 32768;

  // search unit sizing
  localparam int SRW        = 72;
  localparam int MW         = 32;
  localparam int XW         = 22;
  localparam int KW         = 5;
  localparam int DIR_TOP    = 14;
  localparam int RATIO_TOP  = 15;
  localparam int DIR_SHIFT  = 30;
  localparam int RATIO_SHIFT = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_STRIDE_X    = 3'd2,
    REG_STRIDE_Y    = 3'd3,
    REG_ZERO_TOL    = 3'd4,
    REG_REF_MAG     = 3'd5,
    REG_MAX_ARROWS  = 3'd6
  } cfg_reg_t;

  // square: find greatest x with (K*x+L)^2*m (<|<=) r, K=1,L=0 or K=2,L=-1 (odd)
  // linear: find greatest x with x*m <= r
  typedef struct packed {
    logic            square;
    logic            odd;
    logic            strict;
    logic [KW-1:0]   top;
    logic [MW-1:0]   m;
    logic [SRW-1:0]  r;
  } srch_cmd_t;

  typedef struct packed {
    logic            done;
    logic [XW-1:0]   x;
  } srch_res_t;

endpackage

// ===== rtl/vas_search.sv =====
// ----------------------------------------------------------------------------
// vas_search
// Bit-serial monotone search: one result bit per cycle, shift-add only.
// ----------------------------------------------------------------------------
module vas_search (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  vas_pkg::srch_cmd_t  cmd,
  output vas_pkg::srch_res_t  res
);
  import vas_pkg::*;

  logic                  busy;
  logic                  done;
  logic [KW-1:0]         k;
  logic [XW-1:0]         x;
  logic signed [SRW-1:0] e;
  logic signed [SRW-1:0] d;
  logic signed [SRW-1:0] m;
  logic signed [SRW-1:0] r;
  logic                  square;
  logic                  odd;
  logic                  strict;

  logic [KW:0]           kk;
  logic signed [SRW-1:0] trial;
  logic signed [SRW-1:0] d_step;
  logic                  pass;

  always_comb begin
    kk     = {1'b0, k} + (KW+1)'(odd);
    d_step = m <<< kk;
    if (square) begin
      trial = e + (d <<< (kk + 1'b1)) + (m <<< (2 * kk));
    end else begin
      trial = e + (m <<< k);
    end
    pass = strict ? (trial < r) : (trial <= r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        k      <= cmd.top;
        x      <= '0;
        m      <= $signed(SRW'(cmd.m));
        r      <= $signed(cmd.r);
        square <= cmd.square;
        odd    <= cmd.odd;
        strict <= cmd.strict;
        e      <= cmd.odd ? $signed(SRW'(cmd.m)) : '0;
        d      <= cmd.odd ? -$signed(SRW'(cmd.m)) : '0;
      end else if (busy) begin
        if (pass) begin
          e <= trial;
          d <= d + d_step;
          x <= x | (XW'(1) << k);
        end
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.x    = x;

endmodule

// ===== rtl/velocity_arrow_sampler.sv =====
// ----------------------------------------------------------------------------
// velocity_arrow_sampler
// Picks a regular sparse set of grid cells and emits one arrow per sampled fluid cell above the zero tolerance.
// ----------------------------------------------------------------------------
// the first cell of a frame first runs the stride plan, growing strides when
//   the planned arrow count exceeds max_arrows; cells are taken one at a time
//   (in_ready only in IDLE), and a finished arrow waits in the output register
// rst (synchronous) clears counters, plan and handshakes, registers to defaults
module velocity_arrow_sampler #(
  parameter int MAX_GRID  = vas_pkg::MAX_GRID_DEF,
  parameter int VEL_WIDTH = vas_pkg::VEL_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vas_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [VEL_WIDTH-1:0]       vel_x,
  input  logic signed [VEL_WIDTH-1:0]       vel_y,
  input  logic                              is_solid,
  input  logic                              vel_valid,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vas_pkg::POS_W-1:0]         col,
  output logic [vas_pkg::POS_W-1:0]         row,
  output logic signed [vas_pkg::DIR_W-1:0]  dir_x,
  output logic signed [vas_pkg::DIR_W-1:0]  dir_y,
  output logic [vas_pkg::RATIO_W-1:0]       length_ratio
);
  import vas_pkg::*;

  localparam int CW = $clog2(MAX_GRID);      // counter width
  localparam int EW = $clog2(MAX_GRID + 1);  // extent width
  localparam int NW = STRIDE_W + 1;          // next sample position
  localparam int PW = 2 * EW;                // planned arrow count
  localparam int SW = 2 * VEL_WIDTH;         // squared magnitude

  typedef enum logic [5:0] {
    IDLE, P_DX_GO, P_DX_WT, P_DY_GO, P_DY_WT, P_PROD, P_CMP,
    P_SQX, P_NX, P_GX_GO, P_GX_WT, P_SQY, P_NY, P_GY_GO, P_GY_WT, P_FIN,
    C_CHECK, C_SQX, C_SQY, C_SUM, C_TOL, C_SHIFT, C_BX, C_BY, C_S2,
    C_DX_GO, C_DX_WT, C_DY_GO, C_DY_WT, C_RCHK, C_RCMP, C_R_GO, C_R_WT,
    C_EMIT, C_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [REG_W-1:0]  grid_width;
  logic [REG_W-1:0]  grid_height;
  logic [REG_W-1:0]  initial_stride_x;
  logic [REG_W-1:0]  initial_stride_y;
  logic [WORD_W-1:0] zero_tolerance;
  logic [WORD_W-1:0] reference_magnitude;
  logic [WORD_W-1:0] max_arrows;

  // frame state
  logic [CW-1:0]       col_cnt;
  logic [CW-1:0]       row_cnt;
  logic [WORD_W-1:0]   emitted;
  logic [STRIDE_W-1:0] used_sx;
  logic [STRIDE_W-1:0] used_sy;
  logic [EW-1:0]       first_col;
  logic [EW-1:0]       first_row;
  logic [NW-1:0]       next_col;
  logic [NW-1:0]       next_row;
  logic                plan_ready;

  // work registers
  logic signed [VEL_WIDTH-1:0] vx_r;
  logic signed [VEL_WIDTH-1:0] vy_r;
  logic                solid_r;
  logic                valid_r;
  logic [VEL_WIDTH-1:0] bx;
  logic [VEL_WIDTH-1:0] by;
  logic [SW-1:0]       sq_a;
  logic [SW-1:0]       s_sum;
  logic [31:0]         bx2;
  logic [31:0]         by2;
  logic [31:0]         s2;
  logic [EW-1:0]       cnt_x;
  logic [EW-1:0]       cnt_y;
  logic [PW-1:0]       prod;
  logic [STRIDE_W-1:0] gx;
  logic [STRIDE_W-1:0] gy;
  logic [DIR_MAG_W-1:0] dx_mag;
  logic [DIR_MAG_W-1:0] dy_mag;
  logic [RATIO_W-1:0]  ratio;
  logic [63:0]         mprod;

  // derived values
  logic [EW-1:0]        w_eff;
  logic [EW-1:0]        h_eff;
  logic [REG_W-1:0]     sx_eff;
  logic [REG_W-1:0]     sy_eff;
  logic [WORD_W-1:0]    m_eff;
  logic [EW-1:0]        num_x;
  logic [EW-1:0]        num_y;
  logic [VEL_WIDTH-1:0] ax;
  logic [VEL_WIDTH-1:0] ay;
  logic                 col_last;
  logic                 row_last;
  logic                 sample_hit;

  // shared multiplier
  logic [31:0] ma;
  logic [31:0] mb;
  logic        mul_en;

  // shared search unit
  srch_cmd_t srch_cmd;
  srch_res_t srch;
  logic      srch_start;

  function automatic logic [EW-1:0] start_of(input logic [EW-1:0] ext,
                                             input logic [STRIDE_W-1:0] st);
    if (st >= STRIDE_W'(ext)) begin
      return ext >> 1;
    end
    return EW'(st >> 1);
  endfunction

  function automatic logic [EW-1:0] clamp_ext(input logic [REG_W-1:0] e);
    if (e == '0) begin
      return EW'(1);
    end
    if (32'(e) > 32'(MAX_GRID)) begin
      return EW'(MAX_GRID);
    end
    return EW'(e);
  endfunction

  // larger of stride+1 and the least root, saturated
  function automatic logic [STRIDE_W-1:0] grow_sat(input logic [REG_W-1:0] s,
                                                   input logic [XW-1:0] u);
    logic [XW:0] t;
    logic [XW:0] g;
    t = (XW+1)'(u) + 1'b1;
    g = (XW+1)'(s) + 1'b1;
    if (t > g) begin
      g = t;
    end
    if (g > (XW+1)'(STRIDE_MAX)) begin
      return STRIDE_W'(STRIDE_MAX);
    end
    return g[STRIDE_W-1:0];
  endfunction

  always_comb begin
    w_eff  = clamp_ext(grid_width);
    h_eff  = clamp_ext(grid_height);
    sx_eff = (initial_stride_x == '0) ? REG_W'(1) : initial_stride_x;
    sy_eff = (initial_stride_y == '0) ? REG_W'(1) : initial_stride_y;
    m_eff  = (max_arrows == '0) ? WORD_W'(1) : max_arrows;
    num_x  = w_eff - EW'(1) - start_of(w_eff, STRIDE_W'(sx_eff));
    num_y  = h_eff - EW'(1) - start_of(h_eff, STRIDE_W'(sy_eff));
    ax     = vx_r[VEL_WIDTH-1] ? (~vx_r + 1'b1) : vx_r;
    ay     = vy_r[VEL_WIDTH-1] ? (~vy_r + 1'b1) : vy_r;
    col_last = ((EW+1)'(col_cnt) + 1'b1) >= (EW+1)'(w_eff);
    row_last = ((EW+1)'(row_cnt) + 1'b1) >= (EW+1)'(h_eff);
    sample_hit = (NW'(col_cnt) == next_col) && (NW'(row_cnt) == next_row) &&
                 (emitted < m_eff) && !solid_r && valid_r;
  end

  // multiplier operand select
  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (state)
      P_PROD:  begin ma = 32'(cnt_x);          mb = 32'(cnt_y); end
      P_SQX:   begin ma = 32'(sx_eff);         mb = 32'(sx_eff); end
      P_SQY:   begin ma = 32'(sy_eff);         mb = 32'(sy_eff); end
      P_NX,
      P_NY:    begin ma = mprod[31:0];         mb = 32'(prod); end
      C_SQX:   begin ma = 32'(ax);             mb = 32'(ax); end
      C_SQY:   begin ma = 32'(ay);             mb = 32'(ay); end
      C_SUM:   begin ma = 32'(zero_tolerance); mb = 32'(zero_tolerance); end
      C_BX:    begin ma = 32'(bx);             mb = 32'(bx); end
      C_BY:    begin ma = 32'(by);             mb = 32'(by); end
      C_RCHK:  begin
        ma = 32'(reference_magnitude);
        mb = 32'(reference_magnitude);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // search command select
  always_comb begin
    srch_cmd = '0;
    srch_start = state inside {P_DX_GO, P_DY_GO, P_GX_GO, P_GY_GO,
                               C_DX_GO, C_DY_GO, C_R_GO};
    case (state)
      P_DX_GO: begin
        srch_cmd.top = KW'(EW - 1);
        srch_cmd.m   = MW'(sx_eff);
        srch_cmd.r   = SRW'(num_x);
      end
      P_DY_GO: begin
        srch_cmd.top = KW'(EW - 1);
        srch_cmd.m   = MW'(sy_eff);
        srch_cmd.r   = SRW'(num_y);
      end
      P_GX_GO,
      P_GY_GO: begin
        srch_cmd.square = 1'b1;
        srch_cmd.strict = 1'b1;
        srch_cmd.top    = KW'(XW - 1);
        srch_cmd.m      = MW'(m_eff);
        srch_cmd.r      = SRW'(mprod);
      end
      C_DX_GO: begin
        srch_cmd.square = 1'b1;
        srch_cmd.odd    = 1'b1;
        srch_cmd.top    = KW'(DIR_TOP);
        srch_cmd.m      = s2;
        srch_cmd.r      = SRW'(bx2) << DIR_SHIFT;
      end
      C_DY_GO: begin
        srch_cmd.square = 1'b1;
        srch_cmd.odd    = 1'b1;
        srch_cmd.top    = KW'(DIR_TOP);
        srch_cmd.m      = s2;
        srch_cmd.r      = SRW'(by2) << DIR_SHIFT;
      end
      C_R_GO: begin
        srch_cmd.square = 1'b1;
        srch_cmd.odd    = 1'b1;
        srch_cmd.top    = KW'(RATIO_TOP);
        srch_cmd.m      = mprod[MW-1:0];
        srch_cmd.r      = SRW'(s_sum) << RATIO_SHIFT;
      end
      default: srch_cmd = '0;
    endcase
  end

  vas_search u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .cmd   (srch_cmd),
    .res   (srch)
  );

  // configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width          <= REG_W'(64);
      grid_height         <= REG_W'(64);
      initial_stride_x    <= REG_W'(8);
      initial_stride_y    <= REG_W'(8);
      zero_tolerance      <= '0;
      reference_magnitude <= '0;
      max_arrows          <= WORD_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width          <= cfg_data[REG_W-1:0];
        REG_GRID_HEIGHT: grid_height         <= cfg_data[REG_W-1:0];
        REG_STRIDE_X:    initial_stride_x    <= cfg_data[REG_W-1:0];
        REG_STRIDE_Y:    initial_stride_y    <= cfg_data[REG_W-1:0];
        REG_ZERO_TOL:    zero_tolerance      <= cfg_data;
        REG_REF_MAG:     reference_magnitude <= cfg_data;
        REG_MAX_ARROWS:  max_arrows          <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      col_cnt    <= '0;
      row_cnt    <= '0;
      emitted    <= '0;
      plan_ready <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // C_EMIT reloads the output register itself
      if (out_valid && out_ready && (state != C_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (mul_en) begin
        mprod <= 64'(ma) * 64'(mb);
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            vx_r    <= vel_x;
            vy_r    <= vel_y;
            solid_r <= is_solid;
            valid_r <= vel_valid;
            state   <= plan_ready ? C_CHECK : P_DX_GO;
          end
        end
        // frame plan: counts per axis, then grow strides when too many
        P_DX_GO: state <= P_DX_WT;
        P_DX_WT: begin
          if (srch.done) begin
            cnt_x <= srch.x[EW-1:0] + EW'(1);
            state <= P_DY_GO;
          end
        end
        P_DY_GO: state <= P_DY_WT;
        P_DY_WT: begin
          if (srch.done) begin
            cnt_y <= srch.x[EW-1:0] + EW'(1);
            state <= P_PROD;
          end
        end
        P_PROD: state <= P_CMP;
        P_CMP: begin
          prod <= mprod[PW-1:0];
          if (mprod > 64'(m_eff)) begin
            state <= P_SQX;
          end else begin
            gx    <= STRIDE_W'(sx_eff);
            gy    <= STRIDE_W'(sy_eff);
            state <= P_FIN;
          end
        end
        P_SQX:   state <= P_NX;
        P_NX:    state <= P_GX_GO;
        P_GX_GO: state <= P_GX_WT;
        P_GX_WT: begin
          if (srch.done) begin
            gx    <= grow_sat(sx_eff, srch.x);
            state <= P_SQY;
          end
        end
        P_SQY:   state <= P_NY;
        P_NY:    state <= P_GY_GO;
        P_GY_GO: state <= P_GY_WT;
        P_GY_WT: begin
          if (srch.done) begin
            gy    <= grow_sat(sy_eff, srch.x);
            state <= P_FIN;
          end
        end
        P_FIN: begin
          used_sx    <= gx;
          used_sy    <= gy;
          first_col  <= start_of(w_eff, gx);
          first_row  <= start_of(h_eff, gy);
          next_col   <= NW'(start_of(w_eff, gx));
          next_row   <= NW'(start_of(h_eff, gy));
          plan_ready <= 1'b1;
          state      <= C_CHECK;
        end
        // per cell work
        C_CHECK: begin
          bx    <= ax;
          by    <= ay;
          state <= sample_hit ? C_SQX : C_DONE;
        end
        C_SQX: state <= C_SQY;
        C_SQY: begin
          sq_a  <= mprod[SW-1:0];
          state <= C_SUM;
        end
        C_SUM: begin
          s_sum <= sq_a + mprod[SW-1:0];
          state <= C_TOL;
        end
        C_TOL: state <= (64'(s_sum) > mprod) ? C_SHIFT : C_DONE;
        C_SHIFT: begin
          // bring wide components into 16-bit range for the direction
          if (32'(bx) > 32'(COMP_LIMIT) || 32'(by) > 32'(COMP_LIMIT)) begin
            bx <= bx >> 1;
            by <= by >> 1;
          end else begin
            state <= C_BX;
          end
        end
        C_BX: state <= C_BY;
        C_BY: begin
          bx2   <= mprod[31:0];
          state <= C_S2;
        end
        C_S2: begin
          by2   <= mprod[31:0];
          s2    <= bx2 + mprod[31:0];
          state <= C_DX_GO;
        end
        C_DX_GO: state <= C_DX_WT;
        C_DX_WT: begin
          if (srch.done) begin
            dx_mag <= srch.x[DIR_MAG_W-1:0];
            state  <= C_DY_GO;
          end
        end
        C_DY_GO: state <= C_DY_WT;
        C_DY_WT: begin
          if (srch.done) begin
            dy_mag <= srch.x[DIR_MAG_W-1:0];
            state  <= C_RCHK;
          end
        end
        C_RCHK: begin
          ratio <= RATIO_W'(RATIO_ONE);
          state <= (reference_magnitude > zero_tolerance) ? C_RCMP : C_EMIT;
        end
        C_RCMP: state <= (64'(s_sum) < mprod) ? C_R_GO : C_EMIT;
        C_R_GO: state <= C_R_WT;
        C_R_WT: begin
          if (srch.done) begin
            ratio <= srch.x[RATIO_W-1:0];
            state <= C_EMIT;
          end
        end
        C_EMIT: begin
          // hold here until the output register is free
          if (!out_valid || out_ready) begin
            col          <= POS_W'(col_cnt);
            row          <= POS_W'(row_cnt);
            dir_x        <= vx_r[VEL_WIDTH-1] ? (DIR_W'(0) - DIR_W'(dx_mag))
                                              : DIR_W'(dx_mag);
            dir_y        <= vy_r[VEL_WIDTH-1] ? (DIR_W'(0) - DIR_W'(dy_mag))
                                              : DIR_W'(dy_mag);
            length_ratio <= ratio;
            out_valid    <= 1'b1;
            emitted      <= emitted + 1'b1;
            state        <= C_DONE;
          end
        end
        C_DONE: begin
          // raster advance with the current extents
          if (col_last) begin
            col_cnt  <= '0;
            next_col <= NW'(first_col);
            if (row_last) begin
              row_cnt    <= '0;
              next_row   <= NW'(first_row);
              emitted    <= '0;
              plan_ready <= 1'b0;
            end else begin
              row_cnt <= row_cnt + 1'b1;
              if (NW'(row_cnt) == next_row) begin
                next_row <= next_row + NW'(used_sy);
              end
            end
          end else begin
            col_cnt <= col_cnt + 1'b1;
            if (NW'(col_cnt) == next_col) begin
              next_col <= next_col + NW'(used_sx);
            end
          end
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
